[rtl/core/consecutive_run_filter_macros.svh]
// Assertion helper macros for the consecutive run filter.
// Included by the top level; no other dependencies.
`ifndef CONSECUTIVE_RUN_FILTER_MACROS_SVH
`define CONSECUTIVE_RUN_FILTER_MACROS_SVH

// Same-cycle implication.
`define CRF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/crf_pkg.sv]
// Shared types and constants of the consecutive run filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package crf_pkg;

   localparam int NUM_W    = 32;
   localparam int OFF_W    = 48;
   localparam int THR_W    = 6;
   localparam int STRIDE_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_STRIDE = 1'd1;

   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 6'd32;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 16'd512;

   typedef struct packed {
      logic [NUM_W-1:0] number;
      logic [OFF_W-1:0] offset;
   } pend_entry_type;

endpackage

[rtl/core/crf_link_unit.sv]
// Chain test: does the current record extend the previous one.
// Depends on crf_pkg.
`timescale 1ns / 1ps

module crf_link_unit (
   input  logic                          have_prev,
   input  logic [crf_pkg::NUM_W-1:0]     prev_number,
   input  logic [crf_pkg::OFF_W-1:0]     prev_offset,
   input  logic [crf_pkg::STRIDE_W-1:0]  stride,
   input  logic [crf_pkg::NUM_W-1:0]     cur_number,
   input  logic [crf_pkg::OFF_W-1:0]     cur_offset,
   output logic                          chain
);

   logic [crf_pkg::OFF_W:0]   offset_sum;
   logic [crf_pkg::NUM_W-1:0] number_inc;
   logic                      number_ok;
   logic                      offset_ok;

   // Keep the carry so a sum past 48 bits never matches.
   assign offset_sum = {1'b0, prev_offset}
                     + {{(crf_pkg::OFF_W + 1 - crf_pkg::STRIDE_W){1'b0}}, stride};
   assign number_inc = prev_number + crf_pkg::NUM_W'(1);
   assign number_ok  = (prev_number != '1) && (cur_number == number_inc);
   assign offset_ok  = (offset_sum == {1'b0, cur_offset});
   assign chain      = have_prev && number_ok && offset_ok;

endmodule

[rtl/core/crf_pend_mem.sv]
// Pending record buffer: one write port, one registered read port.
// Depends on crf_pkg for the entry type.
`timescale 1ns / 1ps

module crf_pend_mem #(
   parameter int DEPTH = 31,
   parameter int AW    = 5
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  crf_pkg::pend_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output crf_pkg::pend_entry_type rd_data
);

   crf_pkg::pend_entry_type mem_ff [DEPTH];
   crf_pkg::pend_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/consecutive_run_filter.sv]
// Top level of the consecutive run filter: sequencer, run state, output register.
// Depends on crf_pkg, crf_link_unit, crf_pend_mem and the assertion macro header.
`timescale 1ns / 1ps
`include "consecutive_run_filter_macros.svh"

// Consecutive run filter. Records arrive one transaction at a time on the req_
// channel and every record leaves again, in arrival order, on the rsp_ channel
// with a keep flag. A record chains onto the previous one when its number is
// exactly one higher (no wrap past all ones) and its offset exactly
// record_stride higher (no wrap past 48 bits). keep is set on every record of a
// run that reaches run_threshold records (0 and 1 both mean one; values above
// MAX_RUN act as MAX_RUN). Records of a run not yet confirmed wait in a pending
// memory of MAX_RUN-1 entries; they are released with keep=1 once the run is
// confirmed, or with keep=0 when the run breaks or an end_of_list record
// arrives. last_of_burst marks the final result caused by one input
// transaction; a record that only goes into the pending memory yields no
// result. The block takes one record at a time and holds req_stall high while
// it works. Each released pending record is read through the single read
// port of the pending memory (registered read) and then passes the one-deep
// output register; rsp_stall can hold that flow. csr_ready is always high;
// write registers only while the block is idle.
module consecutive_run_filter #(
   parameter int MAX_RUN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // record input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [crf_pkg::NUM_W-1:0]         req_record_number,
   input  logic [crf_pkg::OFF_W-1:0]         req_record_offset,
   input  logic                              req_end_of_list,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [crf_pkg::NUM_W-1:0]         rsp_out_number,
   output logic [crf_pkg::OFF_W-1:0]         rsp_out_offset,
   output logic                              rsp_keep,
   output logic                              rsp_last_of_burst,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [crf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH  = MAX_RUN - 1;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W  = $clog2(MAX_RUN + 1);
   localparam int CMP_W  = (LEN_W > crf_pkg::THR_W) ? LEN_W : crf_pkg::THR_W;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_MID    = 3'd2;
   localparam logic [2:0] S_CUR    = 3'd3;
   localparam logic [2:0] S_FL_RD  = 3'd4;
   localparam logic [2:0] S_FL_OUT = 3'd5;

   // which release pass the flush loop is running
   localparam logic [1:0] PH_BREAK   = 2'd0;
   localparam logic [1:0] PH_CONFIRM = 2'd1;
   localparam logic [1:0] PH_EOL     = 2'd2;

   // ---------------- registers ----------------
   logic [2:0]                       state_ff, state_in;
   logic [1:0]                       phase_ff, phase_in;
   logic [LEN_W-1:0]                 idx_ff, idx_in;
   logic [LEN_W-1:0]                 cnt_ff, cnt_in;
   logic                             fl_keep_ff, fl_keep_in;
   logic                             fl_last_ff, fl_last_in;

   logic [crf_pkg::NUM_W-1:0]        cur_num_ff, cur_num_in;
   logic [crf_pkg::OFF_W-1:0]        cur_off_ff, cur_off_in;
   logic                             cur_eol_ff, cur_eol_in;

   logic [crf_pkg::NUM_W-1:0]        prev_num_ff, prev_num_in;
   logic [crf_pkg::OFF_W-1:0]        prev_off_ff, prev_off_in;
   logic [LEN_W-1:0]                 len_ff, len_in;
   logic                             conf_ff, conf_in;

   // plan for the current record, worked out in S_EVAL
   logic [LEN_W-1:0]                 plen_ff, plen_in;
   logic                             b_conf_ff, b_conf_in;
   logic                             b_reach_ff, b_reach_in;
   logic                             c_emit_ff, c_emit_in;

   logic [crf_pkg::THR_W-1:0]        thr_ff, thr_in;
   logic [crf_pkg::STRIDE_W-1:0]     stride_ff, stride_in;

   logic                             out_valid_ff, out_valid_in;
   logic [crf_pkg::NUM_W-1:0]        out_num_ff, out_num_in;
   logic [crf_pkg::OFF_W-1:0]        out_off_ff, out_off_in;
   logic                             out_keep_ff, out_keep_in;
   logic                             out_last_ff, out_last_in;

   // ---------------- datapath helpers ----------------
   logic                             chain;
   logic                             req_accept;
   logic                             out_free;
   logic [LEN_W-1:0]                 base_len;
   logic [LEN_W-1:0]                 new_len;
   logic                             conf_mid;
   logic                             reach;
   logic                             b_emit;
   logic                             c_emit;
   logic [LEN_W-1:0]                 break_cnt;
   logic [LEN_W-1:0]                 plen_dec;
   logic [LEN_W-1:0]                 idx_inc;

   logic                             mem_wr_en;
   logic                             mem_rd_en;
   crf_pkg::pend_entry_type          mem_wr_data;
   crf_pkg::pend_entry_type          mem_rd_data;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || !rsp_stall;

   crf_link_unit u_link (
      .have_prev   (len_ff != '0),
      .prev_number (prev_num_ff),
      .prev_offset (prev_off_ff),
      .stride      (stride_ff),
      .cur_number  (cur_num_ff),
      .cur_offset  (cur_off_ff),
      .chain       (chain)
   );

   // Run bookkeeping for the record held in cur_*.
   assign base_len  = chain ? len_ff : '0;
   assign conf_mid  = chain && conf_ff;
   assign new_len   = (base_len == LEN_W'(MAX_RUN)) ? base_len : base_len + LEN_W'(1);
   // Saturate the threshold at MAX_RUN: the run length never exceeds it.
   assign reach     = (CMP_W'(new_len) >= CMP_W'(thr_ff)) || (new_len == LEN_W'(MAX_RUN));
   assign b_emit    = conf_mid || reach;
   assign c_emit    = cur_eol_ff && !b_emit;
   assign break_cnt = (!chain && !conf_ff) ? len_ff : '0;
   assign plen_dec  = plen_ff - LEN_W'(1);
   assign idx_inc   = idx_ff + LEN_W'(1);

   assign mem_wr_data.number = cur_num_ff;
   assign mem_wr_data.offset = cur_off_ff;

   crf_pend_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_pend (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (plen_dec[AW-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      fl_keep_in  = fl_keep_ff;
      fl_last_in  = fl_last_ff;
      cur_num_in  = cur_num_ff;
      cur_off_in  = cur_off_ff;
      cur_eol_in  = cur_eol_ff;
      prev_num_in = prev_num_ff;
      prev_off_in = prev_off_ff;
      len_in      = len_ff;
      conf_in     = conf_ff;
      plen_in     = plen_ff;
      b_conf_in   = b_conf_ff;
      b_reach_in  = b_reach_ff;
      c_emit_in   = c_emit_ff;
      thr_in      = thr_ff;
      stride_in   = stride_ff;
      out_num_in  = out_num_ff;
      out_off_in  = out_off_ff;
      out_keep_in = out_keep_ff;
      out_last_in = out_last_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;

      // drop the held result once it is taken
      out_valid_in = out_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            crf_pkg::CSR_RUN_THRESHOLD: thr_in    = csr_wdata[crf_pkg::THR_W-1:0];
            crf_pkg::CSR_RECORD_STRIDE: stride_in = csr_wdata[crf_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cur_num_in = req_record_number;
               cur_off_in = req_record_offset;
               cur_eol_in = req_end_of_list;
               state_in   = S_EVAL;
            end
         end

         // Commit the run state after this record and plan the releases.
         S_EVAL: begin
            prev_num_in = cur_num_ff;
            prev_off_in = cur_off_ff;
            len_in      = cur_eol_ff ? '0 : new_len;
            conf_in     = cur_eol_ff ? 1'b0 : b_emit;
            plen_in     = new_len;
            b_conf_in   = conf_mid;
            b_reach_in  = !conf_mid && reach;
            c_emit_in   = c_emit;
            if (break_cnt != '0) begin
               // release the broken run with keep clear
               phase_in   = PH_BREAK;
               idx_in     = '0;
               cnt_in     = break_cnt;
               fl_keep_in = 1'b0;
               fl_last_in = !b_emit && !c_emit;
               state_in   = S_FL_RD;
            end else begin
               state_in   = S_MID;
            end
         end

         S_MID: begin
            if (b_conf_ff) begin
               state_in = S_CUR;
            end else if (b_reach_ff) begin
               if (plen_ff > LEN_W'(1)) begin
                  // run just confirmed: release the waiting records kept
                  phase_in   = PH_CONFIRM;
                  idx_in     = '0;
                  cnt_in     = plen_dec;
                  fl_keep_in = 1'b1;
                  fl_last_in = 1'b0;
                  state_in   = S_FL_RD;
               end else begin
                  state_in   = S_CUR;
               end
            end else begin
               // hold the record until the run is decided
               mem_wr_en = 1'b1;
               if (c_emit_ff) begin
                  phase_in   = PH_EOL;
                  idx_in     = '0;
                  cnt_in     = plen_ff;
                  fl_keep_in = 1'b0;
                  fl_last_in = 1'b1;
                  state_in   = S_FL_RD;
               end else begin
                  state_in   = S_IDLE;
               end
            end
         end

         S_CUR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_num_in   = cur_num_ff;
               out_off_in   = cur_off_ff;
               out_keep_in  = 1'b1;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_FL_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_FL_OUT;
         end

         S_FL_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_num_in   = mem_rd_data.number;
               out_off_in   = mem_rd_data.offset;
               out_keep_in  = fl_keep_ff;
               out_last_in  = fl_last_ff && (idx_inc == cnt_ff);
               idx_in       = idx_inc;
               if (idx_inc == cnt_ff) begin
                  case (phase_ff)
                     PH_BREAK:   state_in = S_MID;
                     PH_CONFIRM: state_in = S_CUR;
                     PH_EOL:     state_in = S_IDLE;
                     default:    state_in = S_IDLE;
                  endcase
               end else begin
                  state_in = S_FL_RD;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_BREAK;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         len_ff       <= '0;
         conf_ff      <= 1'b0;
         thr_ff       <= crf_pkg::THRESHOLD_RESET;
         stride_ff    <= crf_pkg::STRIDE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         conf_ff      <= conf_in;
         thr_ff       <= thr_in;
         stride_ff    <= stride_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and plan registers: no reset needed
   always_ff @(posedge clock) begin
      fl_keep_ff  <= fl_keep_in;
      fl_last_ff  <= fl_last_in;
      cur_num_ff  <= cur_num_in;
      cur_off_ff  <= cur_off_in;
      cur_eol_ff  <= cur_eol_in;
      prev_num_ff <= prev_num_in;
      prev_off_ff <= prev_off_in;
      plen_ff     <= plen_in;
      b_conf_ff   <= b_conf_in;
      b_reach_ff  <= b_reach_in;
      c_emit_ff   <= c_emit_in;
      out_num_ff  <= out_num_in;
      out_off_ff  <= out_off_in;
      out_keep_ff <= out_keep_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_number    = out_num_ff;
   assign rsp_out_offset    = out_off_ff;
   assign rsp_keep          = out_keep_ff;
   assign rsp_last_of_burst = out_last_ff;

   // ---------------- assertions ----------------
   `CRF_ASSERT_IMPL(a_len_range, clock, reset, 1'b1, len_ff <= LEN_W'(MAX_RUN), "run length above MAX_RUN")
   `CRF_ASSERT_IMPL(a_open_fits, clock, reset, !conf_ff, len_ff <= LEN_W'(DEPTH), "open run exceeds pending memory")
   `CRF_ASSERT_NEXT(a_accept_eval, clock, reset, req_accept, state_ff == S_EVAL, "accepted record not evaluated")
   `CRF_ASSERT_IMPL(a_flush_idx, clock, reset, (state_ff == S_FL_RD) || (state_ff == S_FL_OUT), idx_ff < cnt_ff, "flush index past count")

endmodule
